>>> sv/apic_pkg.sv
package apic_pkg;

  typedef enum logic [1:0] {
    CMD_DELIVER = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_EOI     = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  localparam int unsigned SET_WORDS = 8;
  localparam logic [7:0] CLASS_MASK = 8'hf0;
  localparam logic [7:0] MIN_LEGAL_VECTOR = 8'd16;

  localparam logic [1:0] REG_TPR  = 2'd0;
  localparam logic [1:0] REG_SPUR = 2'd1;
  localparam logic [1:0] REG_SUPP = 2'd2;

  localparam logic [1:0] GRP_ISR = 2'd0;
  localparam logic [1:0] GRP_TMR = 2'd1;
  localparam logic [1:0] GRP_IRR = 2'd2;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] vector;
    logic       level_trigger;
    logic       assert_line;
    logic [4:0] word_index;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_PEND,
    ST_RESCAN
  } state_t;

  typedef struct packed {
    logic [7:0] vector;
    logic       found;
  } scan_res_t;

endpackage

>>> sv/apic_front.sv
// front end: accepts commands, queues them (two entries)
module apic_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  apic_pkg::item_t     item_in,
  input  logic                pop,
  output logic                busy,
  output logic                q_valid,
  output apic_pkg::item_t     q_item
);

  apic_pkg::item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       do_pop;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign do_pop  = pop && q_valid;
  assign q_item  = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

endmodule

>>> sv/apic_scan.sv
// highest set bit search, one 32-bit word per cycle, top word first
module apic_scan #(
  parameter int VECTOR_WORDS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [VECTOR_WORDS*32-1:0]  set_bits,
  output logic                        done,
  output apic_pkg::scan_res_t         res
);

  localparam int WW = (VECTOR_WORDS > 1) ? $clog2(VECTOR_WORDS) : 1;

  logic          running;
  logic [WW-1:0] widx;
  logic [31:0]   word;
  logic [4:0]    bitpos;
  logic          nz;

  assign word = set_bits[widx*32 +: 32];
  assign nz   = (word != 32'd0);

  // priority encode within one word
  always_comb begin
    bitpos = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (word[i]) bitpos = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      widx    <= '0;
      res     <= '0;
    end else begin
      done <= running && !go && (nz || widx == '0);
      if (go) begin
        running <= 1'b1;
        widx    <= WW'(VECTOR_WORDS - 1);
      end else if (running) begin
        if (nz || widx == '0) begin
          running    <= 1'b0;
          res.found  <= nz;
          res.vector <= nz ? 8'({widx, bitpos}) : 8'd0;
        end else begin
          widx <= widx - 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/apic_back.sv
// back end: bit sets and command execution
module apic_back #(
  parameter int VECTOR_WORDS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  apic_pkg::item_t  q_item,
  output logic             pop,
  input  logic [7:0]       task_priority,
  input  logic [7:0]       spurious_vector,
  input  logic             eoi_broadcast_suppress,
  output logic             done,
  output logic             irq_pending,
  output logic [7:0]       ack_vector,
  output logic             eoi_broadcast,
  output logic [7:0]       eoi_vector,
  output logic             illegal_vector,
  output logic [7:0]       processor_priority,
  output logic [31:0]      read_data
);

  localparam int SET_BITS = VECTOR_WORDS * 32;

  apic_pkg::state_t state, state_next;
  apic_pkg::item_t  cur;

  logic [SET_BITS-1:0] irr;
  logic [SET_BITS-1:0] isr;
  logic [SET_BITS-1:0] tmr;
  logic [7:0]          cur_isv;

  logic                scan_go;
  logic                scan_sel_isr;
  logic                scan_done;
  apic_pkg::scan_res_t scan_res;
  logic [SET_BITS-1:0] scan_bits;

  logic [7:0] ppr;
  logic [7:0] ppr_cls;
  logic       kept_vec;
  logic       kept_cur;
  logic       kept_rd;
  logic [7:0] pick;

  // phase flag: after the apply step the last scan computes irq_pending
  logic applied;

  assign ppr_cls  = cur_isv & apic_pkg::CLASS_MASK;
  assign ppr      = (task_priority >= ppr_cls) ? task_priority : ppr_cls;
  assign kept_vec = ({1'b0, cur.vector[7:5]} < 4'(VECTOR_WORDS));
  assign kept_cur = ({1'b0, cur_isv[7:5]} < 4'(VECTOR_WORDS));
  assign kept_rd  = ({1'b0, cur.word_index[2:0]} < 4'(VECTOR_WORDS));
  assign pick     = (scan_res.found &&
                     ((scan_res.vector & apic_pkg::CLASS_MASK) > ppr)) ?
                    scan_res.vector : 8'd0;
  assign scan_bits = scan_sel_isr ? isr : irr;

  apic_scan #(.VECTOR_WORDS(VECTOR_WORDS)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .go       (scan_go),
    .set_bits (scan_bits),
    .done     (scan_done),
    .res      (scan_res)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      apic_pkg::ST_IDLE: if (q_valid) state_next = apic_pkg::ST_SCAN;
      apic_pkg::ST_SCAN: begin
        if (cur.command == apic_pkg::CMD_ACK) state_next = apic_pkg::ST_PEND;
        else state_next = apic_pkg::ST_APPLY;
      end
      apic_pkg::ST_PEND: begin
        if (scan_done) state_next = applied ? apic_pkg::ST_IDLE : apic_pkg::ST_APPLY;
      end
      apic_pkg::ST_APPLY: begin
        if (cur.command == apic_pkg::CMD_EOI && cur_isv != 8'd0)
          state_next = apic_pkg::ST_RESCAN;
        else state_next = apic_pkg::ST_PEND;
      end
      apic_pkg::ST_RESCAN: if (scan_done) state_next = apic_pkg::ST_PEND;
      default: state_next = apic_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop          = (state == apic_pkg::ST_IDLE) && q_valid;
    scan_go      = ((state == apic_pkg::ST_SCAN) && (cur.command == apic_pkg::CMD_ACK)) ||
                   (state == apic_pkg::ST_APPLY) ||
                   ((state == apic_pkg::ST_RESCAN) && scan_done);
    scan_sel_isr = (state == apic_pkg::ST_RESCAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= apic_pkg::ST_IDLE;
      irr     <= '0;
      isr     <= '0;
      tmr     <= '0;
      cur_isv <= 8'd0;
      done    <= 1'b0;
      applied <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == apic_pkg::ST_PEND) && scan_done && applied;
      if (pop) begin
        cur            <= q_item;
        applied        <= 1'b0;
        ack_vector     <= 8'd0;
        eoi_broadcast  <= 1'b0;
        eoi_vector     <= 8'd0;
        illegal_vector <= 1'b0;
        read_data      <= 32'd0;
      end
      // final request scan gives the pending flag and priority
      if (state == apic_pkg::ST_PEND && scan_done && applied) begin
        irq_pending        <= (pick != 8'd0);
        processor_priority <= ppr;
      end
      if (state == apic_pkg::ST_APPLY) begin
        applied <= 1'b1;
        case (cur.command)
          apic_pkg::CMD_DELIVER: begin
            if (cur.vector < apic_pkg::MIN_LEGAL_VECTOR) begin
              illegal_vector <= 1'b1;
            end else if (kept_vec) begin
              irr[cur.vector] <= !cur.level_trigger || cur.assert_line;
              tmr[cur.vector] <= cur.level_trigger;
            end
          end
          apic_pkg::CMD_ACK: begin
            if (pick != 8'd0) begin
              irr[pick] <= 1'b0;
              isr[pick] <= 1'b1;
              cur_isv   <= pick;
              ack_vector <= pick;
            end else begin
              ack_vector <= spurious_vector;
            end
          end
          apic_pkg::CMD_EOI: begin
            if (cur_isv != 8'd0) begin
              // retire the vector in service; the in-service rescan follows
              if (kept_cur) isr[cur_isv] <= 1'b0;
              if (kept_cur && tmr[cur_isv] && !eoi_broadcast_suppress) begin
                eoi_broadcast <= 1'b1;
                eoi_vector    <= cur_isv;
              end
            end
          end
          default: begin
            if (kept_rd) begin
              case (cur.word_index[4:3])
                apic_pkg::GRP_ISR: read_data <= isr[cur.word_index[2:0]*32 +: 32];
                apic_pkg::GRP_TMR: read_data <= tmr[cur.word_index[2:0]*32 +: 32];
                apic_pkg::GRP_IRR: read_data <= irr[cur.word_index[2:0]*32 +: 32];
                default:           read_data <= 32'd0;
              endcase
            end
          end
        endcase
      end
      // eoi rescan: highest remaining in-service vector
      if (state == apic_pkg::ST_RESCAN && scan_done) begin
        cur_isv <= scan_res.vector;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == apic_pkg::ST_IDLE) else $error("pop outside idle");
  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double result");
  a_ppr: assert property (@(posedge clk) disable iff (rst)
    done |-> processor_priority >= task_priority) else $error("ppr below tpr");
`endif

endmodule

>>> sv/apic_interrupt_priority.sv
// Local APIC interrupt priority core.
// Commands enter on start/busy: an item is taken at a clock edge with start
// high and busy low. A two-entry queue sits in front of the execution unit,
// so busy rises only when two commands wait.
// Config registers (task priority, spurious vector, EOI broadcast suppress)
// are written through cfg_we/cfg_index/cfg_data; the user writes them only while
// the block is idle, which the block leaves to the user. Each command gives one
// result, shown for one cycle with done high; the receiver cannot stall it.
// Each scan walks the 32-bit words of a bit set from the top, one word per
// cycle. Deliver and read run one request scan, acknowledge runs two request
// scans, and an end of interrupt with a vector in service runs an in-service
// scan and a request scan. Commands are executed one at a time.
// Reset clears all bit sets, the in-service vector and the queue; registers
// return to 0, 255 and 0.
module apic_interrupt_priority #(
  parameter int VECTOR_WORDS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [7:0]  vector,
  input  logic        level_trigger,
  input  logic        assert_line,
  input  logic [4:0]  word_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic        irq_pending,
  output logic [7:0]  ack_vector,
  output logic        eoi_broadcast,
  output logic [7:0]  eoi_vector,
  output logic        illegal_vector,
  output logic [7:0]  processor_priority,
  output logic [31:0] read_data
);

  apic_pkg::item_t item_in;
  apic_pkg::item_t q_item;
  logic            q_valid;
  logic            pop;
  logic [7:0]      task_priority;
  logic [7:0]      spurious_vector;
  logic            eoi_broadcast_suppress;

  assign item_in = '{command: apic_pkg::cmd_t'(command), vector: vector,
                     level_trigger: level_trigger, assert_line: assert_line,
                     word_index: word_index};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      task_priority          <= 8'd0;
      spurious_vector        <= 8'hff;
      eoi_broadcast_suppress <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        apic_pkg::REG_TPR:  task_priority <= cfg_data;
        apic_pkg::REG_SPUR: spurious_vector <= cfg_data;
        apic_pkg::REG_SUPP: eoi_broadcast_suppress <= cfg_data[0];
        default: ;
      endcase
    end
  end

  apic_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item_in (item_in),
    .pop     (pop),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  apic_back #(.VECTOR_WORDS(VECTOR_WORDS)) u_back (
    .clk                    (clk),
    .rst                    (rst),
    .q_valid                (q_valid),
    .q_item                 (q_item),
    .pop                    (pop),
    .task_priority          (task_priority),
    .spurious_vector        (spurious_vector),
    .eoi_broadcast_suppress (eoi_broadcast_suppress),
    .done                   (done),
    .irq_pending            (irq_pending),
    .ack_vector             (ack_vector),
    .eoi_broadcast          (eoi_broadcast),
    .eoi_vector             (eoi_vector),
    .illegal_vector         (illegal_vector),
    .processor_priority     (processor_priority),
    .read_data              (read_data)
  );

endmodule
